// File: rtl/core/orqm_pkg.sv
// Shared types, widths and helpers for the overwrite ring queue with mean.
`timescale 1ns / 1ps
package orqm_pkg;

  localparam int SLOTS       = 6;
  localparam int ID_W        = 12;
  localparam int H_W         = 9;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS);
  localparam int SUM_W       = H_W + CNT_W;
  localparam int NUM_W       = SUM_W + 1;
  localparam int DEN_W       = CNT_W + 1;
  localparam int DIV_STEPS   = (NUM_W + 1) / 2;
  localparam int NUM_PAD     = 2 * DIV_STEPS;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int SLOT_W      = ID_W + H_W;
  localparam int IN_TDATA_W  = ((ID_W + H_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((H_W + ID_W + H_W + 7) / 8) * 8;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic op_remove;
    logic out_free;
  } status_t;

  function automatic idx_t ring_next(input idx_t i);
    ring_next = (i == IDX_W'(SLOTS - 1)) ? '0 : i + idx_t'(1);
  endfunction

endpackage

// File: rtl/core/orqm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module orqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/orqm_ctrl.sv
// Controller: sequences accept, queue update, mean division and result load.
`timescale 1ns / 1ps
module orqm_ctrl import orqm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        step_nxt  = '0;
        state_nxt = status.op_remove ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/orqm_dp.sv
// Datapath: ring pointers, running sum, slot RAM, radix-4 divider, output register.
`timescale 1ns / 1ps
module orqm_dp import orqm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic                   in_func,
  input  logic [ID_W-1:0]        in_id,
  input  logic [H_W-1:0]         in_height,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  logic               op_r;
  logic [ID_W-1:0]    id_r;
  logic [H_W-1:0]     h_r;
  idx_t               head_r, head_nxt;
  idx_t               tail_r, tail_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [DEN_W-1:0]   den_r;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [NUM_PAD-1:0] num_r, num_nxt;
  logic [NUM_PAD-1:0] q_r, q_nxt;
  logic [ID_W-1:0]    st_id_r;
  logic [H_W-1:0]     st_h_r;
  logic               st_err_r;
  logic               out_valid_r;
  logic [H_W-1:0]     out_mean_r;
  logic [ID_W-1:0]    out_id_r;
  logic [H_W-1:0]     out_h_r;
  logic               out_err_r;

  logic [SLOT_W-1:0]  rdata;
  logic [ID_W-1:0]    rd_id;
  logic [H_W-1:0]     rd_h;
  logic               empty, full, drop, pop, ram_we;
  logic [SUM_W-1:0]   sum_ins;
  logic [CNT_W-1:0]   cnt_ins;
  logic [NUM_W-1:0]   num_load;

  orqm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata ({id_r, h_r}),
    .raddr (head_r),
    .rdata (rdata)
  );

  assign rd_h  = rdata[H_W-1:0];
  assign rd_id = rdata[SLOT_W-1:H_W];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(SLOTS - 1));
  assign drop  = (op_r == FUNC_INSERT) && full;
  assign pop   = (op_r == FUNC_REMOVE) && !empty;
  assign ram_we = cmd.exec && (op_r == FUNC_INSERT);

  assign sum_ins  = sum_r - (drop ? SUM_W'(rd_h) : '0) + SUM_W'(h_r);
  assign cnt_ins  = full ? cnt_r : cnt_r + CNT_W'(1);
  assign num_load = {sum_ins, 1'b0} + NUM_W'(cnt_ins);

  assign status.op_remove = (op_r == FUNC_REMOVE);
  assign status.out_free  = !out_valid_r || out_tready;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    if (cmd.exec) begin
      if (op_r == FUNC_INSERT) begin
        tail_nxt = ring_next(tail_r);
        cnt_nxt  = cnt_ins;
        sum_nxt  = sum_ins;
        if (drop) begin
          head_nxt = ring_next(head_r);
        end
      end else if (pop) begin
        head_nxt = ring_next(head_r);
        cnt_nxt  = cnt_r - CNT_W'(1);
        sum_nxt  = sum_r - SUM_W'(rd_h);
      end
    end
  end

  // two restoring quotient bits per step
  always_comb begin
    logic [DEN_W:0]     t;
    logic [DEN_W-1:0]   r;
    logic [NUM_PAD-1:0] n;
    logic [NUM_PAD-1:0] q;
    r = rem_r;
    n = num_r;
    q = q_r;
    for (int k = 0; k < 2; k++) begin
      t = {r, n[NUM_PAD-1]};
      n = {n[NUM_PAD-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        r = DEN_W'(t - {1'b0, den_r});
        q = {q[NUM_PAD-2:0], 1'b1};
      end else begin
        r = t[DEN_W-1:0];
        q = {q[NUM_PAD-2:0], 1'b0};
      end
    end
    rem_nxt = r;
    num_nxt = n;
    q_nxt   = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_func;
      id_r <= in_id;
      h_r  <= in_height;
    end
    if (cmd.exec) begin
      den_r    <= {cnt_ins, 1'b0};
      rem_r    <= '0;
      num_r    <= NUM_PAD'(num_load);
      q_r      <= '0;
      st_id_r  <= pop ? rd_id : '0;
      st_h_r   <= pop ? rd_h : '0;
      st_err_r <= (op_r == FUNC_REMOVE) && empty;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      q_r   <= q_nxt;
    end
    if (cmd.load_out) begin
      out_mean_r <= (op_r == FUNC_INSERT) ? q_r[H_W-1:0] : '0;
      out_id_r   <= st_id_r;
      out_h_r    <= st_h_r;
      out_err_r  <= st_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_err_r;
  assign out_tdata  = OUT_TDATA_W'({out_h_r, out_id_r, out_mean_r});

endmodule

// File: rtl/core/overwrite_ring_queue_mean.sv
// Flow: an insert passes accept, queue update, the radix-4 mean divider (7 steps) and
// result load; a remove skips the divider. One item is taken at a time: in_tready
// is high only in idle, and a held result stalls the next result load.
// Reset: rst_n synchronous, active low; queue empty, sum zero, output idle.
// Slot RAM contents are not cleared; only queued slots are ever read.
`timescale 1ns / 1ps
module overwrite_ring_queue_mean import orqm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // entry_id[11:0], height[20:12]
  input  logic [0:0]             in_tuser,   // func[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // mean_height[8:0], removed_id[20:9],
                                             // removed_height[29:21]
  output logic [0:0]             out_tuser   // remove_error[0]
);

  cmd_t    cmd;
  status_t status;

  orqm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  orqm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_func    (in_tuser[0]),
    .in_id      (in_tdata[ID_W-1:0]),
    .in_height  (in_tdata[ID_W+H_W-1:ID_W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser[0])
  );

endmodule
